// ===== rtl/core/trbm_pkg.sv =====
// Shared constants and control types for the text run bounding box merger.
package trbm_pkg;

    // Default geometry of the open box list and of coordinates
    localparam int MAX_OPEN_DEF   = 32;
    localparam int COORD_BITS_DEF = 12;

    // Gap countdown width and its value after reset
    localparam int GAP_BITS = 8;
    localparam logic [GAP_BITS-1:0] GAP_RESET = 8'd2;

    // Width of one open box entry: four coordinates, countdown, hit mark
    localparam int ENTRY_W_DEF = 4 * COORD_BITS_DEF + GAP_BITS + 1;

    // Shift controls broadcast along the cell chain
    typedef struct packed {
        logic shift_dn;   // every cell takes its upper neighbor (pop at cell 0)
        logic shift_up;   // every cell takes its lower neighbor (push at cell 0)
    } chain_ctl_t;

endpackage

// ===== rtl/core/trbm_if.sv =====
// Channel interfaces of the text run bounding box merger: runs in, boxes out, config.

interface trbm_item_if
    import trbm_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic                  command;
    logic [COORD_BITS-1:0] run_left;
    logic [COORD_BITS-1:0] run_right;

    modport source (output valid, output command, output run_left, output run_right,
                    input ready);
    modport sink   (input valid, input command, input run_left, input run_right,
                    output ready);
endinterface

interface trbm_result_if
    import trbm_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic                  has_box;
    logic [COORD_BITS-1:0] box_left;
    logic [COORD_BITS-1:0] box_right;
    logic [COORD_BITS-1:0] box_top;
    logic [COORD_BITS-1:0] box_bottom;
    logic                  last;
    logic                  dropped;

    modport source (output valid, output has_box, output box_left, output box_right,
                    output box_top, output box_bottom, output last, output dropped,
                    input ready);
    modport sink   (input valid, input has_box, input box_left, input box_right,
                    input box_top, input box_bottom, input last, input dropped,
                    output ready);
endinterface

interface trbm_cfg_if
    import trbm_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [GAP_BITS-1:0] gap_rows;

    modport source (output valid, output gap_rows, input ready);
    modport sink   (input valid, input gap_rows, output ready);
endinterface

// ===== rtl/core/trbm_cell.sv =====
// One cell of the open box chain: holds one entry, shifts to either neighbor or loads.
module trbm_cell
    import trbm_pkg::*;
#(
    parameter int WIDTH = ENTRY_W_DEF
)(
    input  logic             clk,
    input  chain_ctl_t       ctl,
    input  logic             load,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [WIDTH-1:0] up_data,
    input  logic [WIDTH-1:0] dn_data,
    output logic [WIDTH-1:0] q
);

    logic [WIDTH-1:0] data_reg;
    logic [WIDTH-1:0] data_next;

    // Select the next entry: a direct load wins over a shift
    always_comb
    begin
        data_next = data_reg;
        if (load)
        begin
            data_next = wr_data;
        end
        else if (ctl.shift_dn)
        begin
            data_next = up_data;
        end
        else if (ctl.shift_up)
        begin
            data_next = dn_data;
        end
    end

    // Hold the entry
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign q = data_reg;

endmodule

// ===== rtl/core/text_run_bbox_merger_core.sv =====
// Top level of the text run bounding box merger: cell chain plus sweep control.
//
//   channel  dir   payload                                          transfer when
//   item     in    command, run_left, run_right                     valid & ready
//   result   out   has_box, box_left/right/top/bottom, last, dropped valid & ready
//   cfg      in    gap_rows                                         valid & ready
//
// Open boxes sit in a chain of MAX_OPEN cells, last box of the list in cell 0.
// Every item sweeps the list once through cell 0, one entry per cycle; an end of
// row sweep stalls while a closed box must go out and the result register is
// held by result.ready.
// Reset (rst_n low) empties the list, clears row and drop flag, sets gap_rows 2.
// cfg.ready is always high; item.ready is high only between items.
module text_run_bbox_merger_core
    import trbm_pkg::*;
#(
    parameter int MAX_OPEN   = MAX_OPEN_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
)(
    input  logic          clk,
    input  logic          rst_n,
    trbm_item_if.sink     item,
    trbm_result_if.source result,
    trbm_cfg_if.sink      cfg
);

    localparam int IDX_W   = $clog2(MAX_OPEN);
    localparam int CNT_W   = $clog2(MAX_OPEN + 1);
    localparam int ENTRY_W = 4 * COORD_BITS + GAP_BITS + 1;

    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_OPEN);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    localparam logic [0:0] ST_IDLE  = 1'b0;
    localparam logic [0:0] ST_SWEEP = 1'b1;

    typedef struct packed {
        logic [COORD_BITS-1:0] left;
        logic [COORD_BITS-1:0] right;
        logic [COORD_BITS-1:0] top;
        logic [COORD_BITS-1:0] bottom;
        logic [GAP_BITS-1:0]   countdown;
        logic                  hit;
    } entry_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] left;
        logic [COORD_BITS-1:0] right;
        logic [COORD_BITS-1:0] top;
        logic [COORD_BITS-1:0] bottom;
    } box_t;

    // Control state
    logic [0:0]          state_reg;
    logic                row_end_reg;
    logic [CNT_W-1:0]    rem_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [COORD_BITS-1:0] row_reg;
    logic                drop_reg;
    logic [GAP_BITS-1:0] gap_reg;
    logic                res_valid_reg;
    logic                pend_valid_reg;

    // Payload state
    logic [COORD_BITS-1:0] run_l_reg;
    logic [COORD_BITS-1:0] run_r_reg;
    logic [COORD_BITS-1:0] acc_l_reg;
    logic [COORD_BITS-1:0] acc_r_reg;
    logic [COORD_BITS-1:0] acc_t_reg;
    logic                  any_reg;
    box_t                  pend_reg;
    logic                  res_has_reg;
    box_t                  res_box_reg;
    logic                  res_last_reg;
    logic                  res_drop_reg;

    // Chain signals
    logic [ENTRY_W-1:0]  cell_q [MAX_OPEN];
    logic [MAX_OPEN-1:0] cell_load;
    chain_ctl_t          ctl;
    entry_t              head;
    entry_t              head_upd;
    entry_t              new_box;
    logic                wr_en;
    logic [CNT_W-1:0]    wr_cnt;
    logic [IDX_W-1:0]    wr_idx;

    // Step decode
    logic                  accept;
    logic                  sweeping;
    logic                  finishing;
    logic                  run_ovl;
    logic [GAP_BITS-1:0]   cd_new;
    logic                  closes;
    logic                  survive;
    logic                  push_ok;
    logic                  stall;
    logic                  step;
    logic                  ins;
    logic                  mid_push;
    logic                  fin_push;
    logic                  res_load;

    // Build the chain: cell 0 pops toward the head logic, inserts enter at cell 0
    for (genvar i = 0; i < MAX_OPEN; i++)
    begin : g_cell
        logic [ENTRY_W-1:0] up_d;
        logic [ENTRY_W-1:0] dn_d;

        if (i == MAX_OPEN - 1)
        begin : g_top
            assign up_d = cell_q[i];
        end
        else
        begin : g_mid
            assign up_d = cell_q[i+1];
        end

        if (i == 0)
        begin : g_first
            assign dn_d = new_box;
        end
        else
        begin : g_rest
            assign dn_d = cell_q[i-1];
        end

        assign cell_load[i] = wr_en && (wr_idx == IDX_W'(i));

        trbm_cell #(
            .WIDTH (ENTRY_W)
        ) u_cell (
            .clk     (clk),
            .ctl     (ctl),
            .load    (cell_load[i]),
            .wr_data (head_upd),
            .up_data (up_d),
            .dn_data (dn_d),
            .q       (cell_q[i])
        );
    end

    // Evaluate the entry leaving cell 0
    always_comb
    begin
        head     = entry_t'(cell_q[0]);
        run_ovl  = !((head.left > run_r_reg) || (head.right < run_l_reg));
        cd_new   = head.hit ? gap_reg : (head.countdown - GAP_BITS'(1));
        closes   = (cd_new == '0);
        head_upd = head;
        if (row_end_reg)
        begin
            head_upd.countdown = cd_new;
            head_upd.hit       = 1'b0;
        end
        survive  = row_end_reg ? !closes : !run_ovl;
    end

    // Sequence one sweep step per cycle unless stalled; write survivors back at the list tail
    assign accept    = item.valid && item.ready;
    assign push_ok   = !res_valid_reg || result.ready;
    assign sweeping  = (state_reg == ST_SWEEP) && (rem_reg != '0);
    assign finishing = (state_reg == ST_SWEEP) && (rem_reg == '0);
    assign stall     = row_end_reg && closes && pend_valid_reg && !push_ok;
    assign step      = sweeping && !stall;
    assign wr_en     = step && survive;
    assign wr_cnt    = count_reg - CNT_ONE;
    assign wr_idx    = wr_cnt[IDX_W-1:0];
    assign ins       = finishing && !row_end_reg && (any_reg || (count_reg != CNT_FULL));
    assign mid_push  = step && row_end_reg && closes && pend_valid_reg;
    assign fin_push  = finishing && row_end_reg && push_ok;
    assign res_load  = mid_push || fin_push;

    assign ctl.shift_dn = step;
    assign ctl.shift_up = ins;

    assign new_box = '{left: acc_l_reg, right: acc_r_reg, top: acc_t_reg,
                       bottom: row_reg, countdown: gap_reg, hit: 1'b1};

    // Advance control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            row_end_reg    <= 1'b0;
            rem_reg        <= '0;
            count_reg      <= '0;
            row_reg        <= '0;
            drop_reg       <= 1'b0;
            gap_reg        <= GAP_RESET;
            res_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                gap_reg <= cfg.gap_rows;
            end

            if (res_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                res_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        row_end_reg <= item.command;
                        rem_reg     <= count_reg;
                        state_reg   <= ST_SWEEP;
                    end
                end
                ST_SWEEP:
                begin
                    if (step)
                    begin
                        rem_reg <= rem_reg - CNT_ONE;
                        if (!survive)
                        begin
                            count_reg <= count_reg - CNT_ONE;
                        end
                        if (row_end_reg && closes)
                        begin
                            pend_valid_reg <= 1'b1;
                        end
                    end
                    if (finishing && !row_end_reg)
                    begin
                        if (ins)
                        begin
                            count_reg <= count_reg + CNT_ONE;
                        end
                        else
                        begin
                            drop_reg <= 1'b1;
                        end
                        state_reg <= ST_IDLE;
                    end
                    if (fin_push)
                    begin
                        pend_valid_reg <= 1'b0;
                        drop_reg       <= 1'b0;
                        row_reg        <= row_reg + COORD_BITS'(1);
                        state_reg      <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Hold run, merge accumulators, pending box and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            run_l_reg <= item.run_left;
            run_r_reg <= item.run_right;
            acc_l_reg <= item.run_left;
            acc_r_reg <= item.run_right;
            acc_t_reg <= row_reg;
            any_reg   <= 1'b0;
        end
        else if (step && !row_end_reg && run_ovl)
        begin
            any_reg <= 1'b1;
            if (head.left < acc_l_reg)
            begin
                acc_l_reg <= head.left;
            end
            if (head.right > acc_r_reg)
            begin
                acc_r_reg <= head.right;
            end
            if (head.top < acc_t_reg)
            begin
                acc_t_reg <= head.top;
            end
        end

        if (step && row_end_reg && closes)
        begin
            pend_reg <= '{left: head.left, right: head.right,
                          top: head.top, bottom: head.bottom};
        end

        if (mid_push)
        begin
            res_has_reg  <= 1'b1;
            res_box_reg  <= pend_reg;
            res_last_reg <= 1'b0;
            res_drop_reg <= drop_reg;
        end
        else if (fin_push)
        begin
            res_has_reg  <= pend_valid_reg;
            res_box_reg  <= pend_valid_reg ? pend_reg : '0;
            res_last_reg <= 1'b1;
            res_drop_reg <= drop_reg;
        end
    end

    // Drive the channels
    assign item.ready        = (state_reg == ST_IDLE);
    assign cfg.ready         = 1'b1;
    assign result.valid      = res_valid_reg;
    assign result.has_box    = res_has_reg;
    assign result.box_left   = res_box_reg.left;
    assign result.box_right  = res_box_reg.right;
    assign result.box_top    = res_box_reg.top;
    assign result.box_bottom = res_box_reg.bottom;
    assign result.last       = res_last_reg;
    assign result.dropped    = res_drop_reg;

    // The list never holds more than MAX_OPEN boxes
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("open box count above capacity");

    // An insert always finds a free cell
    a_ins_room: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.shift_up |-> (count_reg != CNT_FULL))
        else $error("insert into a full chain");

    // No closed box stays pending between items
    a_pend_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !pend_valid_reg)
        else $error("pending box left after end of row");

    // Results come only from an end of row sweep
    a_push_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past((state_reg == ST_SWEEP) && row_end_reg))
        else $error("result produced outside an end of row");

endmodule
